FILE: src/assert_macros.svh
// Assertion macros shared by the RTL of the deviation bar builder.
// Both macros expect clk and rst_n in scope of the asserting module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/mdwc_pkg.sv
// Shared types, constants and coefficient table for the deviation bar builder.
// No dependencies; used by mdwc_isqrt and metric_deviation_window_candle.
package mdwc_pkg;

  localparam int unsigned NUM_METRICS = 5;
  localparam int unsigned MIDX_W      = 3;
  localparam int unsigned AVG_W       = 25;
  localparam int unsigned COEF_W      = 27;
  localparam int unsigned MUL_A_W     = 33;
  localparam int unsigned MUL_B_W     = 27;
  localparam int unsigned PROD_W      = MUL_A_W + MUL_B_W;
  localparam int unsigned ACC_W       = 46;
  localparam int unsigned SQ_W        = 48;

  typedef logic [MIDX_W-1:0]        midx_t;
  typedef logic signed [AVG_W-1:0]  avg_t;
  typedef logic [COEF_W-1:0]        coef_t;

  localparam midx_t M_MOM   = 3'd0;
  localparam midx_t M_PEAK  = 3'd1;
  localparam midx_t M_WIDTH = 3'd2;
  localparam midx_t M_TILT  = 3'd3;
  localparam midx_t M_TRANS = 3'd4;

  // Weight / (scale^2 * 2.56) in Q32, rounded to nearest.
  localparam logic [63:0] K_MOM_Q32   = ((64'd28 << 32) + 64'd4608) / 64'd9216;
  localparam logic [63:0] K_PEAK_Q32  = ((64'd22 << 32) + 64'd1152) / 64'd2304;
  localparam logic [63:0] K_TILT_Q32  = ((64'd16 << 32) + 64'd4608) / 64'd9216;
  localparam logic [63:0] K_WIDTH_Q32 = ((64'd180000 << 22) + 64'd61952) / 64'd123904;
  localparam logic [63:0] K_TRANS_Q32 = ((64'd160000 << 18) + 64'd18432) / 64'd36864;

  typedef enum logic {
    REG_WINDOW = 1'b0,
    REG_ALPHA  = 1'b1
  } cfg_reg_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SQR  = 7'b0000010,
    S_MHI  = 7'b0000100,
    S_MLO  = 7'b0001000,
    S_ROOT = 7'b0010000,
    S_BAR  = 7'b0100000,
    S_EMA  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] root;
  } sqrt_rsp_t;

  function automatic coef_t k_coef(input midx_t idx);
    coef_t k;
    unique case (idx)
      M_MOM:   k = K_MOM_Q32[COEF_W-1:0];
      M_PEAK:  k = K_PEAK_Q32[COEF_W-1:0];
      M_WIDTH: k = K_WIDTH_Q32[COEF_W-1:0];
      M_TILT:  k = K_TILT_Q32[COEF_W-1:0];
      M_TRANS: k = K_TRANS_Q32[COEF_W-1:0];
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

FILE: src/mdwc_isqrt.sv
// Iterative 32-bit integer square root, two radicand bits per cycle.
// Depends on mdwc_pkg for the request and response structs.
module mdwc_isqrt (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mdwc_pkg::sqrt_req_t   req,
  output mdwc_pkg::sqrt_rsp_t   rsp
);
  import mdwc_pkg::*;

  logic        busy_r;
  logic        done_r;
  logic [3:0]  cnt_r;
  logic [31:0] rem_r;
  logic [31:0] root_r;
  logic [31:0] bitv;
  logic [31:0] trial;
  logic        fits;

  assign bitv  = 32'(1) << {~cnt_r, 1'b0};
  assign trial = root_r + bitv;
  assign fits  = rem_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'hF) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.radicand;
      root_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r  <= rem_r - trial;
        root_r <= (root_r >> 1) + bitv;
      end else begin
        root_r <= root_r >> 1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r[15:0];

endmodule

FILE: src/metric_deviation_window_candle.sv
// Top level of the deviation bar builder: sequencer, shared multiplier, bar state.
// Depends on mdwc_pkg, mdwc_isqrt and assert_macros.svh.
//
// Usage:
//   Input requests (in_valid/in_ready) carry one metric frame each. The block
//   takes one request at a time; in_ready is high only while it is idle.
//   A frame passes through these steps in order: products on the
//   shared 33x27 multiplier for the five weighted squares, the
//   16-step square root unit, a bar update step and a multiplier step
//   for each of the five running averages. The next request is taken only
//   once the block is back in idle after the last average update.
//   A frame that closes its bar produces one result request on out_valid /
//   out_ready, registered in the bar update step. The result sits in an
//   output register; the block keeps working on further frames while it
//   waits. If a frame closes a bar while the previous result is still
//   not taken, the bar update step holds until out_ready.
//   cfg_we writes window_ms (index 0) or average_alpha (index 1).
//   Reset (rst_n low, synchronous) restores the default registers, drops
//   any pending result, clears the averages' seed flag and the open bar.
`include "assert_macros.svh"

module metric_deviation_window_candle (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  mdwc_pkg::cfg_reg_t       cfg_index,
  input  logic [15:0]              cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [31:0]              in_time_ms,
  input  logic signed [15:0]       in_momentary_lufs,
  input  logic signed [15:0]       in_true_peak_db,
  input  logic signed [15:0]       in_stereo_width,
  input  logic signed [15:0]       in_spectral_tilt,
  input  logic [15:0]              in_transient_density,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [15:0]              out_bar_open,
  output logic [15:0]              out_bar_close,
  output logic [15:0]              out_bar_high,
  output logic [15:0]              out_bar_low,
  output logic [31:0]              out_bar_start_ms,
  output logic [31:0]              out_bar_end_ms,
  output logic signed [15:0]       out_snap_momentary,
  output logic signed [15:0]       out_snap_true_peak,
  output logic signed [15:0]       out_snap_width,
  output logic signed [15:0]       out_snap_tilt,
  output logic [15:0]              out_snap_transient
);
  import mdwc_pkg::*;

  state_t              state_r, state_nxt;
  midx_t               idx_r;
  logic                avg_valid_r;
  logic                bar_active_r;
  logic                out_valid_r;
  logic                root_start_r;
  logic [15:0]         window_r;
  logic [15:0]         alpha_r;

  logic [31:0]         t_r;
  logic [15:0]         mom_r, peak_r, width_r, tilt_r, trans_r;
  avg_t                avg_r [NUM_METRICS];
  logic [SQ_W-1:0]     sq_r;
  logic [ACC_W-1:0]    acc_r;
  logic [31:0]         bar_start_r;
  logic [15:0]         cur_open_r, cur_close_r, cur_high_r, cur_low_r;

  logic [15:0]         o_open_r, o_close_r, o_high_r, o_low_r;
  logic [31:0]         o_start_r, o_end_r;
  logic [15:0]         o_mom_r, o_peak_r, o_width_r, o_tilt_r, o_trans_r;

  avg_t                x_sel, avg_sel, diff, avg_new;
  logic [23:0]         mag;
  coef_t               k_cur;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [43:0]  step;

  sqrt_req_t           sq_req;
  sqrt_rsp_t           sq_rsp;
  logic                sat;
  logic [15:0]         score;
  logic [31:0]         start_eff, elapsed;
  logic [15:0]         open_eff, high_eff, low_eff;
  logic                emit, bar_hold, accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    unique case (idx_r)
      M_MOM:   x_sel = avg_t'({mom_r[15], mom_r, 8'h00});
      M_PEAK:  x_sel = avg_t'({peak_r[15], peak_r, 8'h00});
      M_WIDTH: x_sel = avg_t'({width_r[15], width_r, 8'h00});
      M_TILT:  x_sel = avg_t'({tilt_r[15], tilt_r, 8'h00});
      M_TRANS: x_sel = avg_t'({1'b0, trans_r, 8'h00});
      default: x_sel = '0;
    endcase
  end

  assign avg_sel = avg_r[idx_r];
  assign diff    = avg_t'(x_sel - avg_sel);
  assign mag     = diff[AVG_W-1] ? 24'(-diff) : 24'(diff);
  assign k_cur   = k_coef(idx_r);

  always_comb begin
    unique case (state_r)
      S_SQR: begin
        mul_a = {9'b0, mag};
        mul_b = {3'b0, mag};
      end
      S_MHI: begin
        mul_a = {17'b0, sq_r[47:32]};
        mul_b = k_cur;
      end
      S_MLO: begin
        mul_a = {1'b0, sq_r[31:0]};
        mul_b = k_cur;
      end
      S_EMA: begin
        mul_a = {{8{diff[AVG_W-1]}}, diff};
        mul_b = {11'b0, alpha_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign step    = prod[PROD_W-1:16];
  assign avg_new = avg_t'(avg_sel + step[AVG_W-1:0]);

  assign sq_req.start    = root_start_r;
  assign sq_req.radicand = acc_r[31:0];

  mdwc_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

  assign sat       = |acc_r[ACC_W-1:32];
  assign score     = sat ? 16'hFFFF : sq_rsp.root;
  assign start_eff = bar_active_r ? bar_start_r : t_r;
  assign elapsed   = t_r - start_eff;
  assign emit      = elapsed >= {16'b0, window_r};
  assign bar_hold  = emit && out_valid_r && !out_ready;
  assign open_eff  = bar_active_r ? cur_open_r : score;
  assign high_eff  = (bar_active_r && cur_high_r >= score) ? cur_high_r : score;
  assign low_eff   = (bar_active_r && cur_low_r <= score) ? cur_low_r : score;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_SQR;
      S_SQR:  state_nxt = S_MHI;
      S_MHI:  state_nxt = S_MLO;
      S_MLO:  state_nxt = (idx_r == M_TRANS) ? S_ROOT : S_SQR;
      S_ROOT: if (sq_rsp.done) state_nxt = S_BAR;
      S_BAR:  if (!bar_hold) state_nxt = S_EMA;
      S_EMA:  if (idx_r == M_TRANS) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= M_MOM;
      avg_valid_r  <= 1'b0;
      bar_active_r <= 1'b0;
      out_valid_r  <= 1'b0;
      root_start_r <= 1'b0;
      window_r     <= 16'd6000;
      alpha_r      <= 16'd3932;
    end else begin
      state_r      <= state_nxt;
      root_start_r <= (state_r == S_MLO) && (idx_r == M_TRANS);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW: window_r <= cfg_wdata;
          REG_ALPHA:  alpha_r  <= cfg_wdata;
        endcase
      end
      if (accept) begin
        avg_valid_r <= 1'b1;
        idx_r       <= M_MOM;
      end
      if ((state_r == S_MLO || state_r == S_EMA) && idx_r != M_TRANS) begin
        idx_r <= idx_r + 3'd1;
      end
      if (state_r == S_MLO && idx_r == M_TRANS) begin
        idx_r <= M_MOM;
      end
      if (state_r == S_BAR && !bar_hold) begin
        bar_active_r <= !emit;
      end
      if (state_r == S_BAR && !bar_hold && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      t_r     <= in_time_ms;
      mom_r   <= in_momentary_lufs;
      peak_r  <= in_true_peak_db;
      width_r <= in_stereo_width;
      tilt_r  <= in_spectral_tilt;
      trans_r <= in_transient_density;
      acc_r   <= '0;
      if (!avg_valid_r) begin
        avg_r[M_MOM]   <= avg_t'({in_momentary_lufs[15], in_momentary_lufs, 8'h00});
        avg_r[M_PEAK]  <= avg_t'({in_true_peak_db[15], in_true_peak_db, 8'h00});
        avg_r[M_WIDTH] <= avg_t'({in_stereo_width[15], in_stereo_width, 8'h00});
        avg_r[M_TILT]  <= avg_t'({in_spectral_tilt[15], in_spectral_tilt, 8'h00});
        avg_r[M_TRANS] <= avg_t'({1'b0, in_transient_density, 8'h00});
      end
    end
    if (state_r == S_SQR) begin
      sq_r <= prod[SQ_W-1:0];
    end
    if (state_r == S_MHI) begin
      acc_r <= acc_r + prod[ACC_W-1:0];
    end
    if (state_r == S_MLO) begin
      acc_r <= acc_r + ACC_W'(prod[57:32]);
    end
    if (state_r == S_EMA) begin
      avg_r[idx_r] <= avg_new;
    end
    if (state_r == S_BAR && !bar_hold) begin
      bar_start_r <= start_eff;
      cur_open_r  <= open_eff;
      cur_close_r <= score;
      cur_high_r  <= high_eff;
      cur_low_r   <= low_eff;
      if (emit) begin
        o_open_r  <= open_eff;
        o_close_r <= score;
        o_high_r  <= high_eff;
        o_low_r   <= low_eff;
        o_start_r <= start_eff;
        o_end_r   <= t_r;
        o_mom_r   <= mom_r;
        o_peak_r  <= peak_r;
        o_width_r <= width_r;
        o_tilt_r  <= tilt_r;
        o_trans_r <= trans_r;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bar_open       = o_open_r;
  assign out_bar_close      = o_close_r;
  assign out_bar_high       = o_high_r;
  assign out_bar_low        = o_low_r;
  assign out_bar_start_ms   = o_start_r;
  assign out_bar_end_ms     = o_end_r;
  assign out_snap_momentary = o_mom_r;
  assign out_snap_true_peak = o_peak_r;
  assign out_snap_width     = o_width_r;
  assign out_snap_tilt      = o_tilt_r;
  assign out_snap_transient = o_trans_r;

  `ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready high after accept")
  `ASSERT_NEXT(a_seeded_after_accept, in_valid && in_ready, avg_valid_r, "averages not seeded")
  `ASSERT_ALWAYS(a_high_over_low, !out_valid || out_bar_high >= out_bar_low, "bar high below low")
  `ASSERT_ALWAYS(a_high_over_ends, !out_valid || (out_bar_high >= out_bar_open && out_bar_high >= out_bar_close), "bar high below open or close")

endmodule
